[rtl/rgb2hsv_pkg.sv]
// shared types and constants for the rgb to hsv converter
// no dependencies

package rgb2hsv_pkg;

    localparam int CHANNEL_BITS_DEF = 8;

    // twice the hue step of 960 sixteenths per sector fraction, used in round-to-nearest form
    localparam int HUE_SCALE2 = 1920;
    // hue quotient never exceeds 960
    localparam int HUE_Q_BITS = 10;

    localparam int HUE_BITS   = 13;
    localparam int OFF_GREEN  = 1920;
    localparam int OFF_BLUE   = 3840;
    localparam int HUE_FULL   = 5760;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue_sixteenths;
        logic [7:0]          saturation;
        logic [7:0]          brightness;
        logic                achromatic;
    } hsv_t;

    // per-pixel data that rides alongside the dividers
    typedef struct packed {
        logic [7:0] brightness;
        sector_t    sector;
        logic       negative;
        logic       achromatic;
    } side_t;

endpackage

[rtl/rgb2hsv_front.sv]
// front end: max/min, delta, sector select and divider operand setup, two stages
// depends on rgb2hsv_pkg

module rgb2hsv_front #(
    parameter int CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF,
    parameter int NUM_BITS     = 2 * CHANNEL_BITS + 1,
    parameter int DEN_BITS     = CHANNEL_BITS + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rgb2hsv_pkg::pixel_t   pixel,
    output logic                  out_valid,
    output logic [NUM_BITS-1:0]   sat_num,
    output logic [DEN_BITS-1:0]   sat_den,
    output logic [NUM_BITS-1:0]   hue_num,
    output logic [DEN_BITS-1:0]   hue_den,
    output rgb2hsv_pkg::side_t    side
);

    localparam logic [NUM_BITS-1:0] SAT_K = NUM_BITS'(2 * ((1 << CHANNEL_BITS) - 1));
    localparam logic [NUM_BITS-1:0] HUE_K = NUM_BITS'(rgb2hsv_pkg::HUE_SCALE2);

    logic [CHANNEL_BITS-1:0] r, g, b;
    logic [CHANNEL_BITS-1:0] mx, mn;
    logic [CHANNEL_BITS-1:0] op_a, op_b;
    rgb2hsv_pkg::sector_t    sector;

    logic                    valid1_reg;
    logic [CHANNEL_BITS-1:0] mx_reg, delta_reg, mag_reg;
    logic                    neg_reg;
    rgb2hsv_pkg::sector_t    sector_reg;

    logic                    valid2_reg;
    logic [NUM_BITS-1:0]     sat_num_reg, hue_num_reg;
    logic [DEN_BITS-1:0]     sat_den_reg, hue_den_reg;
    rgb2hsv_pkg::side_t      side_reg, side_next;

    assign r = CHANNEL_BITS'(pixel.red);
    assign g = CHANNEL_BITS'(pixel.green);
    assign b = CHANNEL_BITS'(pixel.blue);

    always_comb
    begin
        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        if (mx == r)
        begin
            sector = rgb2hsv_pkg::SECT_RED;
            op_a   = g;
            op_b   = b;
        end
        else if (mx == g)
        begin
            sector = rgb2hsv_pkg::SECT_GREEN;
            op_a   = b;
            op_b   = r;
        end
        else
        begin
            sector = rgb2hsv_pkg::SECT_BLUE;
            op_a   = r;
            op_b   = g;
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg     <= mx;
        delta_reg  <= mx - mn;
        neg_reg    <= op_a < op_b;
        mag_reg    <= (op_a < op_b) ? op_b - op_a : op_a - op_b;
        sector_reg <= sector;
    end

    // stage 2: rounded-division operands, zero denominators forced to one
    always_comb
    begin
        side_next.brightness = 8'(mx_reg);
        side_next.sector     = sector_reg;
        side_next.negative   = neg_reg;
        side_next.achromatic = (delta_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_num_reg <= NUM_BITS'(delta_reg) * SAT_K + NUM_BITS'(mx_reg);
        sat_den_reg <= (mx_reg == '0) ? DEN_BITS'(1) : {mx_reg, 1'b0};
        hue_num_reg <= NUM_BITS'(mag_reg) * HUE_K + NUM_BITS'(delta_reg);
        hue_den_reg <= (delta_reg == '0) ? DEN_BITS'(1) : {delta_reg, 1'b0};
        side_reg    <= side_next;
    end

    assign out_valid = valid2_reg;
    assign sat_num   = sat_num_reg;
    assign sat_den   = sat_den_reg;
    assign hue_num   = hue_num_reg;
    assign hue_den   = hue_den_reg;
    assign side      = side_reg;

endmodule

[rtl/rgb2hsv_div.sv]
// pipelined restoring divider, one quotient bit per register stage
// no dependencies; quotient must fit in Q_BITS

module rgb2hsv_div #(
    parameter int NUM_BITS = 17,
    parameter int DEN_BITS = 9,
    parameter int Q_BITS   = 10
) (
    input  logic                clk,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [Q_BITS-1:0]   quo
);

    localparam int WW = (NUM_BITS > DEN_BITS + Q_BITS) ? NUM_BITS : DEN_BITS + Q_BITS;

    logic [WW-1:0]       rem_reg [Q_BITS-1];
    logic [DEN_BITS-1:0] den_reg [Q_BITS-1];
    logic [Q_BITS-1:0]   quo_reg [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_stage
        localparam int SH = Q_BITS - 1 - k;

        logic [WW-1:0]       rem_in, trial, rem_next;
        logic [DEN_BITS-1:0] den_in;
        logic [Q_BITS-1:0]   quo_in, quo_next;
        logic [WW:0]         diff;

        if (k == 0)
        begin : g_first
            assign rem_in = WW'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial    = WW'(den_in) << SH;
        assign diff     = {1'b0, rem_in} - {1'b0, trial};
        assign rem_next = diff[WW] ? rem_in : diff[WW-1:0];
        assign quo_next = quo_in | (Q_BITS'(!diff[WW]) << SH);

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= quo_next;
        end

        if (k < Q_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[Q_BITS-1];

endmodule

[rtl/rgb_to_hsv.sv]
// rgb to hsv converter top level: front end, two dividers, hue assembly
// depends on rgb2hsv_pkg, rgb2hsv_front, rgb2hsv_div

// Takes one pixel per clock: busy is always low, so a beat is accepted on every
// cycle with start high. The result appears on result with done high after the
// 2 front-end stages, one stage per quotient bit in the saturation and hue
// dividers, which run side by side with max(CHANNEL_BITS, 10) stages, and one
// output stage. done is high for one cycle only and cannot be held off; results
// come out in input order. Hue is in sixteenths of a degree, saturation and
// brightness are the low 8 bits of their values.

module rgb_to_hsv #(
    parameter int CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rgb2hsv_pkg::pixel_t pixel,
    output logic                done,
    output rgb2hsv_pkg::hsv_t   result
);

    localparam int NUM_BITS = (2 * CHANNEL_BITS + 1 > CHANNEL_BITS + 11)
                              ? 2 * CHANNEL_BITS + 1 : CHANNEL_BITS + 11;
    localparam int DEN_BITS = CHANNEL_BITS + 1;
    localparam int Q_BITS   = (CHANNEL_BITS > rgb2hsv_pkg::HUE_Q_BITS)
                              ? CHANNEL_BITS : rgb2hsv_pkg::HUE_Q_BITS;
    localparam int LATENCY  = Q_BITS + 3;

    logic                front_valid;
    logic [NUM_BITS-1:0] sat_num, hue_num;
    logic [DEN_BITS-1:0] sat_den, hue_den;
    rgb2hsv_pkg::side_t  front_side;
    logic [Q_BITS-1:0]   sat_q, hue_q;

    logic [Q_BITS-1:0]   valid_reg;
    rgb2hsv_pkg::side_t  side_reg [Q_BITS];

    rgb2hsv_pkg::side_t  side_out;
    logic signed [14:0]  offset, hue_raw, hue_wrap;
    rgb2hsv_pkg::hsv_t   result_next, result_reg;
    logic                done_reg;

    assign busy = 1'b0;

    rgb2hsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .NUM_BITS     (NUM_BITS),
        .DEN_BITS     (DEN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pixel     (pixel),
        .out_valid (front_valid),
        .sat_num   (sat_num),
        .sat_den   (sat_den),
        .hue_num   (hue_num),
        .hue_den   (hue_den),
        .side      (front_side)
    );

    rgb2hsv_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS),
        .Q_BITS   (Q_BITS)
    ) u_sat_div (
        .clk (clk),
        .num (sat_num),
        .den (sat_den),
        .quo (sat_q)
    );

    rgb2hsv_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS),
        .Q_BITS   (Q_BITS)
    ) u_hue_div (
        .clk (clk),
        .num (hue_num),
        .den (hue_den),
        .quo (hue_q)
    );

    // side data delay matching the divider depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q_BITS-2:0], front_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= front_side;
        for (int i = 1; i < Q_BITS; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_out = side_reg[Q_BITS-1];

    // hue assembly
    always_comb
    begin
        case (side_out.sector)
            rgb2hsv_pkg::SECT_RED:   offset = 15'sd0;
            rgb2hsv_pkg::SECT_GREEN: offset = 15'(rgb2hsv_pkg::OFF_GREEN);
            rgb2hsv_pkg::SECT_BLUE:  offset = 15'(rgb2hsv_pkg::OFF_BLUE);
            default:                 offset = 15'sd0;
        endcase
        hue_raw = side_out.negative
                  ? offset - $signed({1'b0, 14'(hue_q)})
                  : offset + $signed({1'b0, 14'(hue_q)});
        hue_wrap = (hue_raw < 0) ? hue_raw + 15'(rgb2hsv_pkg::HUE_FULL) : hue_raw;

        result_next.hue_sixteenths = side_out.achromatic
                                     ? '0 : rgb2hsv_pkg::HUE_BITS'(hue_wrap);
        result_next.saturation     = 8'(sat_q);
        result_next.brightness     = side_out.brightness;
        result_next.achromatic     = side_out.achromatic;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[Q_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("accepted beat did not complete on time");

    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.hue_sixteenths < rgb2hsv_pkg::HUE_BITS'(rgb2hsv_pkg::HUE_FULL))
        else $error("hue out of range");

    a_gray_hue : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.achromatic |-> result.hue_sixteenths == '0)
        else $error("achromatic beat with nonzero hue");

    a_gray_sat : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.achromatic |-> result.saturation == '0)
        else $error("achromatic beat with nonzero saturation");

endmodule

[tb/rgb_to_hsv_checker.sv]
// result checker for the rgb to hsv converter: predicts each accepted pixel
// and compares the results in order; depends on rgb2hsv_pkg
`timescale 1ns / 1ps

module rgb_to_hsv_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  rgb2hsv_pkg::pixel_t pixel,
    input  logic                done,
    input  rgb2hsv_pkg::hsv_t   result,
    output int unsigned         mismatch_count,
    output int unsigned         pending_count
);

    localparam int unsigned CHAN_MAX = (1 << rgb2hsv_pkg::CHANNEL_BITS_DEF) - 1;
    localparam int unsigned REPORT_LIMIT = 10;

    rgb2hsv_pkg::hsv_t expected_hsv[$];

    function automatic rgb2hsv_pkg::hsv_t predict_hsv(rgb2hsv_pkg::pixel_t p);
        int unsigned          r, g, b, peak, lo, delta, mag, quot, sat;
        int                   diff, hue, offset;
        rgb2hsv_pkg::sector_t sect;
        rgb2hsv_pkg::hsv_t    h;
        r = p.red & CHAN_MAX;
        g = p.green & CHAN_MAX;
        b = p.blue & CHAN_MAX;
        peak = r;
        lo = r;
        if (g > peak) peak = g;
        if (b > peak) peak = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = peak - lo;
        sat = 0;
        if (peak != 0)
            sat = (delta * CHAN_MAX * 2 + peak) / (2 * peak);
        hue = 0;
        if (delta != 0)
        begin
            // priority red, green, blue when maxima are equal
            if (peak == r) sect = rgb2hsv_pkg::SECT_RED;
            else if (peak == g) sect = rgb2hsv_pkg::SECT_GREEN;
            else sect = rgb2hsv_pkg::SECT_BLUE;
            case (sect)
                rgb2hsv_pkg::SECT_RED:
                begin
                    diff = int'(g) - int'(b);
                    offset = 0;
                end
                rgb2hsv_pkg::SECT_GREEN:
                begin
                    diff = int'(b) - int'(r);
                    offset = rgb2hsv_pkg::OFF_GREEN;
                end
                default:
                begin
                    diff = int'(r) - int'(g);
                    offset = rgb2hsv_pkg::OFF_BLUE;
                end
            endcase
            mag = (diff < 0) ? -diff : diff;
            // halves away from zero
            quot = (rgb2hsv_pkg::HUE_SCALE2 * mag + delta) / (2 * delta);
            hue = ((diff < 0) ? -int'(quot) : int'(quot)) + offset;
            if (hue < 0)
                hue += rgb2hsv_pkg::HUE_FULL;
        end
        h.hue_sixteenths = hue[rgb2hsv_pkg::HUE_BITS-1:0];
        h.saturation     = sat[7:0];
        h.brightness     = peak[7:0];
        h.achromatic     = (delta == 0);
        return h;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb2hsv_pkg::hsv_t want;
        if (!rst_n)
        begin
            expected_hsv.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_hsv.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected result hue %0d sat %0d val %0d achr %0b",
                                 $time, result.hue_sixteenths, result.saturation,
                                 result.brightness, result.achromatic);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_hsv.pop_front();
                    if (result.hue_sixteenths !== want.hue_sixteenths ||
                        result.saturation !== want.saturation ||
                        result.brightness !== want.brightness ||
                        result.achromatic !== want.achromatic)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $write("%0t: mismatch exp hue %0d sat %0d val %0d achr %0b,",
                                   $time, want.hue_sixteenths, want.saturation,
                                   want.brightness, want.achromatic);
                            $display(" got hue %0d sat %0d val %0d achr %0b",
                                     result.hue_sixteenths, result.saturation,
                                     result.brightness, result.achromatic);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_hsv.insert(expected_hsv.size(), predict_hsv(pixel));
            pending_count <= expected_hsv.size();
        end
    end

endmodule

[tb/rgb_to_hsv_tb.sv]
// testbench top for the rgb to hsv converter: drives pixel beats in bursts
// and gives the verdict; depends on rgb2hsv_pkg, rgb_to_hsv, rgb_to_hsv_checker
`timescale 1ns / 1ps

module rgb_to_hsv_tb;

    localparam int RANDOM_PIXELS = 730;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    rgb2hsv_pkg::pixel_t pixel;
    logic                done;
    rgb2hsv_pkg::hsv_t   result;
    int unsigned         mismatch_count;
    int unsigned         pending_count;
    int                  idle_cycles;

    rgb_to_hsv u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    rgb_to_hsv_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pixel          (pixel),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ends the run when no beat moves for too long
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic rgb2hsv_pkg::pixel_t random_pixel();
        rgb2hsv_pkg::pixel_t p;
        logic [7:0]          hi, lo;
        int unsigned         pick;
        p = 24'($urandom);
        pick = $urandom_range(0, 99);
        hi = 8'($urandom);
        lo = 8'($urandom_range(0, hi));
        if (pick < 15)
        begin
            // gray
            p.red = hi;
            p.green = hi;
            p.blue = hi;
        end
        else if (pick < 30)
        begin
            // two channels tie for the max
            case ($urandom_range(0, 2))
                0: p = {hi, hi, lo};
                1: p = {lo, hi, hi};
                default: p = {hi, lo, hi};
            endcase
        end
        else if (pick < 40)
        begin
            // channel extremes
            case ($urandom_range(0, 3))
                0: p.red = 8'h00;
                1: p.red = 8'hff;
                2: p.green = 8'h00;
                default: p.blue = 8'hff;
            endcase
        end
        return p;
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_pixel(input rgb2hsv_pkg::pixel_t p);
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    initial
    begin
        int sent;
        int burst;
        int gap;
        bit paused;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pixel(24'h000000);
        send_pixel(24'hffffff);
        send_pixel(24'h808080);
        send_pixel(24'h010101);
        send_pixel(24'hff0000);
        send_pixel(24'h00ff00);
        send_pixel(24'h0000ff);
        send_pixel(24'hffff00);
        send_pixel(24'h00ffff);
        send_pixel(24'hff00ff);
        hold_off(3);
        send_pixel(24'hc84948);
        send_pixel(24'hc84849);
        send_pixel(24'h020101);
        send_pixel(24'hfe0001);
        send_pixel(24'h01fe00);
        send_pixel(24'h7f80ff);
        send_pixel(24'h55aaff);
        send_pixel(24'hff8000);
        send_pixel(24'h80ff00);
        send_pixel(24'hff0080);
        send_pixel(24'h0100ff);
        send_pixel(24'h5a5a5b);
        hold_off(1);

        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_PIXELS)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_PIXELS; i++)
            begin
                send_pixel(random_pixel());
                sent++;
            end
            if (!paused && sent >= RANDOM_PIXELS / 2)
            begin
                // let the pipeline run dry
                paused = 1'b1;
                start <= 1'b0;
                while (pending_count != 0)
                    @(negedge clk);
            end
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                hold_off(gap);
            end
        end
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[rgb_to_hsv.f]
rtl/rgb2hsv_pkg.sv
rtl/rgb2hsv_front.sv
rtl/rgb2hsv_div.sv
rtl/rgb_to_hsv.sv
tb/rgb_to_hsv_checker.sv
tb/rgb_to_hsv_tb.sv
